// File: sv/fbd_pkg.sv
// Shared types, widths and codes for the half-block dirty framebuffer.
// No dependencies; every other file of the block depends on this package.
package fbd_pkg;

    // Default geometry limits
    localparam int DEF_MAX_COLS      = 128;
    localparam int DEF_MAX_CELL_ROWS = 64;

    // Field widths
    localparam int FUNC_W     = 3;
    localparam int COORD_W    = 8;
    localparam int CHAN_W     = 8;
    localparam int WORD_W     = 7;
    localparam int CELL_IDX_W = 13;
    localparam int RGB_W      = 24;
    localparam int COLS_W     = 8;
    localparam int ROWS_W     = 7;
    localparam int BIT_W      = 6;
    localparam int WORD_BITS  = 64;
    localparam int DIV_W      = CELL_IDX_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_COLS      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_ROWS = 1'd1;

    // Reset values of the geometry registers
    localparam logic [COLS_W-1:0] RST_COLS = 8'd80;
    localparam logic [ROWS_W-1:0] RST_ROWS = 7'd24;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_SET_PIXEL = 3'd0;
    localparam logic [FUNC_W-1:0] FN_FILL      = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_MARK_ROW  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_MARK_RECT = 3'd4;
    localparam logic [FUNC_W-1:0] FN_ENCODE    = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [WORD_W-1:0]  word_index;
    } t_item;

    typedef struct packed {
        logic [CELL_IDX_W-1:0] cell_index;
        logic [RGB_W-1:0]      fore_colour;
        logic [RGB_W-1:0]      back_colour;
        logic                  last;
    } t_res;

    // Controller to datapath
    typedef struct packed {
        logic init_step;
        logic load;
        logic px_set;
        logic rect_init;
        logic rect_step;
        logic div_start;
        logic scan_init;
        logic scan_rd;
        logic scan_adv;
        logic rd_top;
        logic rd_bot;
        logic capt;
        logic push;
        logic flush;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic              init_last;
        logic [FUNC_W-1:0] func;
        logic              rect_empty;
        logic              rect_last;
        logic              word_ok;
        logic              div_done;
        logic              scan_end;
        logic              dirty_bit;
        logic              pend_valid;
        logic              out_free;
    } t_stat;

endpackage

// File: sv/fbd_if.sv
// Valid/ready channel interfaces for requests and encode results.
// Depends on fbd_pkg for field widths.
interface fbd_in_if;
    logic                        valid;
    logic                        ready;
    logic [fbd_pkg::FUNC_W-1:0]  func;
    logic [fbd_pkg::COORD_W-1:0] x_start;
    logic [fbd_pkg::COORD_W-1:0] y_start;
    logic [fbd_pkg::COORD_W-1:0] x_end;
    logic [fbd_pkg::COORD_W-1:0] y_end;
    logic [fbd_pkg::CHAN_W-1:0]  red;
    logic [fbd_pkg::CHAN_W-1:0]  green;
    logic [fbd_pkg::CHAN_W-1:0]  blue;
    logic [fbd_pkg::WORD_W-1:0]  word_index;

    modport source (output valid, func, x_start, y_start, x_end, y_end, red, green, blue,
                    word_index, input ready);
    modport sink   (input valid, func, x_start, y_start, x_end, y_end, red, green, blue,
                    word_index, output ready);
endinterface

interface fbd_out_if;
    logic                           valid;
    logic                           ready;
    logic [fbd_pkg::CELL_IDX_W-1:0] cell_index;
    logic [fbd_pkg::RGB_W-1:0]      fore_colour;
    logic [fbd_pkg::RGB_W-1:0]      back_colour;
    logic                           last;

    modport source (output valid, cell_index, fore_colour, back_colour, last, input ready);
    modport sink   (input valid, cell_index, fore_colour, back_colour, last, output ready);
endinterface

// File: sv/fbd_div.sv
// Restoring divider, one quotient bit per cycle; splits a cell index into row and column.
// Depends on fbd_pkg.
module fbd_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [fbd_pkg::DIV_W-1:0]    i_dividend,
    input  logic [fbd_pkg::COLS_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [fbd_pkg::DIV_W-1:0]    o_quot,
    output logic [fbd_pkg::COLS_W-1:0]   o_rem
);
    import fbd_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  r_q;
    logic [COLS_W-1:0] r_r;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [COLS_W:0]   trial;
    logic              ge;

    // Shift in the next dividend bit and try to subtract
    assign trial = {r_r, r_q[DIV_W-1]};
    assign ge    = (trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
        end else if (r_busy) begin
            r_q <= {r_q[DIV_W-2:0], ge};
            r_r <= ge ? COLS_W'(trial - {1'b0, i_divisor}) : trial[COLS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

// File: sv/fbd_dp.sv
// Datapath: geometry registers, pixel and dirty memories, loop counters, result registers.
// Depends on fbd_pkg and fbd_div; driven by fbd_ctrl through t_cmd.
module fbd_dp #(
    parameter int MAX_COLS      = fbd_pkg::DEF_MAX_COLS,
    parameter int MAX_CELL_ROWS = fbd_pkg::DEF_MAX_CELL_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fbd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fbd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  fbd_pkg::t_item                  i_item,
    input  fbd_pkg::t_cmd                   i_cmd,
    output fbd_pkg::t_stat                  o_stat,
    output logic                            o_res_valid,
    output fbd_pkg::t_res                   o_res,
    input  logic                            i_res_ready
);
    import fbd_pkg::*;

    localparam int PIX_DEPTH  = MAX_COLS * 2 * MAX_CELL_ROWS;
    localparam int PAW        = $clog2(PIX_DEPTH);
    localparam int NUM_CELLS  = MAX_COLS * MAX_CELL_ROWS;
    localparam int CW         = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int WORD_COUNT = (NUM_CELLS + WORD_BITS - 1) / WORD_BITS;
    localparam int CNT_W      = COLS_W + ROWS_W;

    // Geometry registers and latched request
    logic [COLS_W-1:0]  r_cols;
    logic [ROWS_W-1:0]  r_rows;
    t_item              r_item;

    // Loop and scan state
    logic [COORD_W-1:0]    r_x;
    logic [COORD_W-1:0]    r_y;
    logic [BIT_W:0]        r_b;
    logic [DIV_W-1:0]      r_row;
    logic [COLS_W-1:0]     r_col;
    logic [PAW-1:0]        r_swp;

    // Memories and read data
    logic [RGB_W-1:0] pix_mem [PIX_DEPTH];
    logic             dirty_mem [NUM_CELLS];
    logic [RGB_W-1:0] r_pix_q;
    logic             r_dirty_q;

    // Result staging
    logic [RGB_W-1:0] r_top;
    t_res             r_new;
    t_res             r_pend;
    logic             r_pend_valid;
    t_res             r_out;
    logic             r_out_valid;

    logic [COLS_W-1:0]     w;
    logic [ROWS_W-1:0]     rows_e;
    logic [COORD_W-1:0]    h;
    logic [CNT_W-1:0]      count;
    logic [COORD_W-1:0]    x_clip, y_clip, y_row_end;
    logic [COORD_W:0]      y_next;
    logic [COORD_W-1:0]    xs, xe, ys, ye;
    logic                  rect_empty, rect_last, x_wrap, wr_pix_en, px_ok;
    logic [COORD_W-1:0]    mark_x, mark_y;
    logic [CNT_W-1:0]      mark_idx;
    logic [PAW-1:0]        wr_addr, top_addr, bot_addr;
    logic [CELL_IDX_W-1:0] scan_idx;
    logic [RGB_W-1:0]      rgb;
    logic                  out_free, div_done;
    logic [DIV_W-1:0]      div_quot;
    logic [COLS_W-1:0]     div_rem;
    logic                  pix_we, dirty_we, dirty_wdata;
    logic [PAW-1:0]        pix_addr;
    logic [RGB_W-1:0]      pix_wdata;
    logic [CW-1:0]         dirty_addr;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= RST_COLS;
            r_rows <= RST_ROWS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COLS:      r_cols <= i_cfg_data;
                REG_CELL_ROWS: r_rows <= i_cfg_data[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturated geometry
    assign w      = (r_cols == '0) ? COLS_W'(1) :
                    ((r_cols > MAX_COLS) ? COLS_W'(MAX_COLS) : r_cols);
    assign rows_e = (r_rows == '0) ? ROWS_W'(1) :
                    ((r_rows > MAX_CELL_ROWS) ? ROWS_W'(MAX_CELL_ROWS) : r_rows);
    assign h      = {rows_e, 1'b0};
    assign count  = {{ROWS_W{1'b0}}, w} * {{COLS_W{1'b0}}, rows_e};
    assign rgb    = {r_item.red, r_item.green, r_item.blue};

    // Rectangle bounds, clipped to the grid
    assign x_clip    = (r_item.x_end < w) ? r_item.x_end : w;
    assign y_clip    = (r_item.y_end < h) ? r_item.y_end : h;
    assign y_next    = {1'b0, r_item.y_start} + 1'b1;
    assign y_row_end = (y_next < {1'b0, h}) ? y_next[COORD_W-1:0] : h;

    always_comb begin
        xs = '0;
        xe = '0;
        ys = '0;
        ye = '0;
        case (r_item.func)
            FN_FILL, FN_MARK_RECT: begin
                xs = r_item.x_start;
                xe = x_clip;
                ys = r_item.y_start;
                ye = y_clip;
            end
            FN_CLEAR: begin
                xe = w;
                ye = h;
            end
            FN_MARK_ROW: begin
                xe = w;
                ys = r_item.y_start;
                ye = y_row_end;
            end
            default: ;
        endcase
    end

    assign rect_empty = (xs >= xe) || (ys >= ye);
    assign x_wrap     = (({1'b0, r_x} + 1'b1) == {1'b0, xe});
    assign rect_last  = x_wrap && (({1'b0, r_y} + 1'b1) == {1'b0, ye});
    assign wr_pix_en  = (r_item.func == FN_FILL) || (r_item.func == FN_CLEAR);
    assign px_ok      = (r_item.x_start < w) && (r_item.y_start < h);

    // Write coordinates: single pixel or rectangle walker
    assign mark_x   = i_cmd.px_set ? r_item.x_start : r_x;
    assign mark_y   = i_cmd.px_set ? r_item.y_start : r_y;
    assign mark_idx = {{(CNT_W-ROWS_W){1'b0}}, mark_y[COORD_W-1:1]} *
                      {{ROWS_W{1'b0}}, w} + {{ROWS_W{1'b0}}, mark_x};
    assign wr_addr  = PAW'(32'(mark_y) * MAX_COLS + 32'(mark_x));

    // Encode scan addressing
    assign scan_idx = {r_item.word_index, r_b[BIT_W-1:0]};
    assign top_addr = PAW'(32'({r_row, 1'b0}) * MAX_COLS + 32'(r_col));
    assign bot_addr = PAW'((32'({r_row, 1'b0}) + 1) * MAX_COLS + 32'(r_col));

    // Pixel memory port
    always_comb begin
        pix_we    = 1'b0;
        pix_addr  = r_swp;
        pix_wdata = '0;
        if (i_cmd.init_step) begin
            pix_we = 1'b1;
        end else if (i_cmd.px_set) begin
            pix_we    = px_ok;
            pix_addr  = wr_addr;
            pix_wdata = rgb;
        end else if (i_cmd.rect_step) begin
            pix_we    = wr_pix_en;
            pix_addr  = wr_addr;
            pix_wdata = rgb;
        end else if (i_cmd.rd_top) begin
            pix_addr = top_addr;
        end else if (i_cmd.rd_bot) begin
            pix_addr = bot_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            pix_mem[pix_addr] <= pix_wdata;
        end
        r_pix_q <= pix_mem[pix_addr];
    end

    // Dirty bit memory port
    always_comb begin
        dirty_we    = 1'b0;
        dirty_addr  = CW'(r_swp);
        dirty_wdata = 1'b1;
        if (i_cmd.init_step) begin
            dirty_we    = (r_swp < NUM_CELLS);
            dirty_wdata = 1'b0;
        end else if (i_cmd.px_set) begin
            dirty_we   = px_ok;
            dirty_addr = CW'(mark_idx);
        end else if (i_cmd.rect_step) begin
            dirty_we   = 1'b1;
            dirty_addr = CW'(mark_idx);
        end else if (i_cmd.scan_rd) begin
            dirty_addr = CW'(scan_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (dirty_we) begin
            dirty_mem[dirty_addr] <= dirty_wdata;
        end
        r_dirty_q <= dirty_mem[dirty_addr];
    end

    // Row/column of the first cell of the word
    fbd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({r_item.word_index, {BIT_W{1'b0}}}),
        .i_divisor  (w),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Sweep counter for the post-reset clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swp <= '0;
        end else if (i_cmd.init_step) begin
            r_swp <= r_swp + 1'b1;
        end
    end

    // Request latch, rectangle walker and scan counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.rect_init) begin
            r_x <= xs;
            r_y <= ys;
        end else if (i_cmd.rect_step) begin
            if (x_wrap) begin
                r_x <= xs;
                r_y <= r_y + 1'b1;
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
        if (i_cmd.scan_init) begin
            r_b   <= '0;
            r_row <= div_quot;
            r_col <= div_rem;
        end else if (i_cmd.scan_adv) begin
            r_b <= r_b + 1'b1;
            if (({1'b0, r_col} + 1'b1) == {1'b0, w}) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
        if (i_cmd.rd_bot) begin
            r_top <= r_pix_q;
        end
        if (i_cmd.capt) begin
            r_new.cell_index  <= scan_idx;
            r_new.fore_colour <= r_top;
            r_new.back_colour <= r_pix_q;
            r_new.last        <= 1'b0;
        end
        if (i_cmd.push) begin
            r_pend <= r_new;
        end
    end

    // Pending result and output register
    assign out_free = !r_out_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.push) begin
                r_pend_valid <= 1'b1;
                if (r_pend_valid) begin
                    r_out_valid <= 1'b1;
                end
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
                r_out_valid  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && r_pend_valid) begin
            r_out <= r_pend;
        end else if (i_cmd.flush) begin
            r_out      <= r_pend;
            r_out.last <= 1'b1;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // Status
    assign o_stat.init_last  = (r_swp == PAW'(PIX_DEPTH - 1));
    assign o_stat.func       = r_item.func;
    assign o_stat.rect_empty = rect_empty;
    assign o_stat.rect_last  = rect_last;
    assign o_stat.word_ok    = (r_item.word_index < WORD_COUNT);
    assign o_stat.div_done   = div_done;
    assign o_stat.scan_end   = r_b[BIT_W] ||
                               ({{(CNT_W-CELL_IDX_W){1'b0}}, scan_idx} >= count);
    assign o_stat.dirty_bit  = r_dirty_q;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = out_free;

    // Walker stays inside the clipped rectangle
    a_rect_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rect_step |-> (r_x < xe) && (r_y < ye))
        else $error("rectangle walker outside its bounds");

    // Encode reads only cells of the active grid
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_rd |-> ({{(CNT_W-CELL_IDX_W){1'b0}}, scan_idx} < count))
        else $error("dirty read beyond active cell count");

    // A pending result never overwrites an undelivered one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && r_pend_valid) || i_cmd.flush |-> !r_out_valid || i_res_ready)
        else $error("output register overwritten");

endmodule

// File: sv/fbd_ctrl.sv
// Controller state machine: sequences clearing pass, writes, rectangle walks and encode scans.
// Depends on fbd_pkg; talks to fbd_dp only through t_cmd and t_stat.
module fbd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  fbd_pkg::t_stat  i_stat,
    output fbd_pkg::t_cmd   o_cmd
);
    import fbd_pkg::*;

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_EXEC     = 4'd2;
    localparam logic [3:0] S_RECT     = 4'd3;
    localparam logic [3:0] S_DIV      = 4'd4;
    localparam logic [3:0] S_SCAN_RD  = 4'd5;
    localparam logic [3:0] S_SCAN_CHK = 4'd6;
    localparam logic [3:0] S_RD_BOT   = 4'd7;
    localparam logic [3:0] S_CAPT     = 4'd8;
    localparam logic [3:0] S_PUSH     = 4'd9;
    localparam logic [3:0] S_FLUSH    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_stat.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (i_stat.func)
                    FN_SET_PIXEL: o_cmd.px_set = 1'b1;
                    FN_FILL, FN_CLEAR, FN_MARK_ROW, FN_MARK_RECT: begin
                        if (!i_stat.rect_empty) begin
                            o_cmd.rect_init = 1'b1;
                            n_state         = S_RECT;
                        end
                    end
                    FN_ENCODE: begin
                        if (i_stat.word_ok) begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIV;
                        end
                    end
                    default: ;
                endcase
            end
            S_RECT: begin
                o_cmd.rect_step = 1'b1;
                if (i_stat.rect_last) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_stat.scan_end) begin
                    n_state = i_stat.pend_valid ? S_FLUSH : S_IDLE;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_stat.dirty_bit) begin
                    o_cmd.rd_top = 1'b1;
                    n_state      = S_RD_BOT;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_RD_BOT: begin
                o_cmd.rd_bot = 1'b1;
                n_state      = S_CAPT;
            end
            S_CAPT: begin
                o_cmd.capt = 1'b1;
                n_state    = S_PUSH;
            end
            S_PUSH: begin
                // older result goes out only when the output register can take it
                if (!i_stat.pend_valid || i_stat.out_free) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.scan_adv = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Pixel port has one user per cycle
    a_pix_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.init_step, o_cmd.px_set, o_cmd.rect_step, o_cmd.rd_top, o_cmd.rd_bot}))
        else $error("pixel memory port contention");

    // Final result only leaves when there is one and room for it
    a_flush_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.flush |-> i_stat.pend_valid && i_stat.out_free)
        else $error("flush without pending result or room");

    // Dirty data is checked only right after its read
    a_chk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN_CHK |-> $past(r_state) == S_SCAN_RD)
        else $error("dirty bit checked without a read");

endmodule

// File: sv/half_block_dirty_framebuffer.sv
// Half-block dirty framebuffer, top level: ties controller and datapath to the channels.
// Depends on fbd_pkg, fbd_if, fbd_ctrl and fbd_dp.
//
// Usage: requests enter on i_req (valid/ready); encode results leave on o_rsp.
// Geometry (cols, cell_rows) is written on i_cfg_* by the user while the block is idle;
// the block itself does not enforce this. After reset the block clears the pixel store
// (MAX_COLS * 2 * MAX_CELL_ROWS entries, 16384 by default) and the dirty mask, one
// entry a cycle, with i_req.ready low. Steps per request on the single-port memories:
//   set pixel: one write of the pixel and its dirty bit, if inside the grid.
//   fill, clear, mark row, mark rect: one step per pixel of the clipped area.
//   encode: the row/column divider, then a read and check per scanned bit, plus a top
//   read, bottom read, capture and push per dirty cell, then any last result is flushed.
// One result is held back until the next is found so that last can be set.
// When o_rsp.ready stays low the scan waits with one result in the output register
// and one pending; nothing is dropped. Requests are taken only between operations.
module half_block_dirty_framebuffer #(
    parameter int MAX_COLS      = fbd_pkg::DEF_MAX_COLS,
    parameter int MAX_CELL_ROWS = fbd_pkg::DEF_MAX_CELL_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fbd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fbd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    fbd_in_if.sink                          i_req,
    fbd_out_if.source                       o_rsp
);
    import fbd_pkg::*;

    t_item item;
    t_cmd  cmd;
    t_stat stat;
    t_res  res;
    logic  res_valid;
    logic  in_ready;

    assign item.func       = i_req.func;
    assign item.x_start    = i_req.x_start;
    assign item.y_start    = i_req.y_start;
    assign item.x_end      = i_req.x_end;
    assign item.y_end      = i_req.y_end;
    assign item.red        = i_req.red;
    assign item.green      = i_req.green;
    assign item.blue       = i_req.blue;
    assign item.word_index = i_req.word_index;
    assign i_req.ready     = in_ready;

    fbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fbd_dp #(
        .MAX_COLS      (MAX_COLS),
        .MAX_CELL_ROWS (MAX_CELL_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_item      (item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (o_rsp.ready)
    );

    assign o_rsp.valid       = res_valid;
    assign o_rsp.cell_index  = res.cell_index;
    assign o_rsp.fore_colour = res.fore_colour;
    assign o_rsp.back_colour = res.back_colour;
    assign o_rsp.last        = res.last;

endmodule
